@@ sv/rced_pkg.sv @@
// Shared widths and sideband types for the ray/cylinder entry distance unit.
`timescale 1ns / 1ps

package rced_pkg;

  // Quotient magnitude bits before saturation, and signed quotient width
  localparam int QB = 41;
  localparam int QW = QB + 1;

  // Root bits of the discriminant square root (radicand is 2*SQK bits)
  localparam int SQK = 52;

  // Field and intermediate widths
  localparam int PW   = 52;  // p = ox*dx + oz*dz, signed
  localparam int AW   = 36;  // a = dx^2 + dz^2, unsigned; also divisor width
  localparam int DW33 = 33;  // coordinate differences, signed
  localparam int DIRW = 18;  // direction components, signed
  localparam int LIMW = 31;  // range limit, unsigned

  // Items that ride alongside the square root
  typedef struct packed {
    logic signed [PW-1:0]   p;
    logic [AW-1:0]          a;
    logic signed [DW33-1:0] nb;
    logic signed [DW33-1:0] nt;
    logic signed [DIRW-1:0] dy;
    logic [LIMW-1:0]        lim;
    logic                   bad;
    logic                   hmiss;
    logic                   vin;
    logic                   dneg;
  } sq_side_t;

  // Items that ride alongside the dividers
  typedef struct packed {
    logic [LIMW-1:0] lim;
    logic            bad;
    logic            hmiss;
    logic            dyz;
    logic            az;
    logic            vin;
    logic            dneg;
  } div_side_t;

endpackage

@@ sv/rced_sqrt_pipe.sv @@
// Pipelined digit-by-digit integer square root, one root bit per stage.
`timescale 1ns / 1ps

module rced_sqrt_pipe #(
  parameter int K = 52
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     in_valid,
  input  logic [2*K-1:0]           rad,
  input  rced_pkg::sq_side_t       in_side,
  output logic                     out_valid,
  output logic [K-1:0]             root_out,
  output rced_pkg::sq_side_t       out_side
);

  logic [K-1:0]                valid;
  rced_pkg::sq_side_t          side [0:K-1];
  logic [K-1:0][K+1:0]         rem;
  logic [K-1:0][K-1:0]         root;
  logic [K-1:0][2*K-1:0]       rs;
  logic [K-1:0][K+1:0]         rem_next;
  logic [K-1:0][K-1:0]         root_next;
  logic [K-1:0][2*K-1:0]       rs_next;

  always_comb begin
    logic [K+3:0]   t;
    logic [K+3:0]   trial;
    logic [K+1:0]   pr_rem;
    logic [K-1:0]   pr_root;
    logic [2*K-1:0] pr_rs;
    for (int i = 0; i < K; i++) begin
      if (i == 0) begin
        pr_rem  = '0;
        pr_root = '0;
        pr_rs   = rad;
      end else begin
        pr_rem  = rem[i-1];
        pr_root = root[i-1];
        pr_rs   = rs[i-1];
      end
      t     = {pr_rem, pr_rs[2*K-1 -: 2]};
      trial = (K+4)'({pr_root, 2'b01});
      if (t >= trial) begin
        rem_next[i]  = (K+2)'(t - trial);
        root_next[i] = {pr_root[K-2:0], 1'b1};
      end else begin
        rem_next[i]  = (K+2)'(t);
        root_next[i] = {pr_root[K-2:0], 1'b0};
      end
      rs_next[i] = pr_rs << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (en) begin
      valid <= {valid[K-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem  <= rem_next;
      root <= root_next;
      rs   <= rs_next;
      side[0] <= in_side;
      for (int i = 1; i < K; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  assign out_valid = valid[K-1];
  assign root_out  = root[K-1];
  assign out_side  = side[K-1];

endmodule

@@ sv/rced_div_pipe.sv @@
// Pipelined restoring dividers, one quotient bit per stage, saturating quotient.
`timescale 1ns / 1ps

module rced_div_pipe #(
  parameter int NW    = 68,
  parameter int DW    = 36,
  parameter int LANES = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  rced_pkg::div_side_t                 in_side,
  input  logic [LANES-1:0][NW-1:0]            num,
  input  logic [LANES-1:0][DW-1:0]            den,
  input  logic [LANES-1:0]                    neg,
  output logic                                out_valid,
  output rced_pkg::div_side_t                 out_side,
  output logic [LANES-1:0][rced_pkg::QW-1:0]  quot
);

  localparam int QB = rced_pkg::QB;
  localparam int HW = NW - QB;
  localparam int MW = (HW > DW) ? HW : DW;
  localparam logic [QB-1:0] TSAT = {1'b1, {(QB-1){1'b0}}};

  logic [QB:0]                      valid;
  rced_pkg::div_side_t              side [0:QB];
  logic [QB:0][LANES-1:0][DW-1:0]   rem;
  logic [QB:0][LANES-1:0][DW-1:0]   dv;
  logic [QB:0][LANES-1:0][QB-1:0]   low;
  logic [QB:0][LANES-1:0][QB-1:0]   q;
  logic [QB:0][LANES-1:0]           sat;
  logic [QB:0][LANES-1:0]           sg;
  logic [QB-1:0][LANES-1:0][DW-1:0] rem_next;
  logic [QB-1:0][LANES-1:0][QB-1:0] q_next;
  logic [LANES-1:0]                 sat_in;
  logic [LANES-1:0][DW-1:0]         rem_in;
  logic [LANES-1:0][QB:0]           quot_next;

  // Quotient of 2^QB or more saturates at once; otherwise the top part fits the divisor
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      sat_in[l] = MW'(num[l][NW-1:QB]) >= MW'(den[l]);
      rem_in[l] = DW'(num[l][NW-1:QB]);
    end
  end

  always_comb begin
    logic [DW:0] t;
    for (int s = 0; s < QB; s++) begin
      for (int l = 0; l < LANES; l++) begin
        t = {rem[s][l], low[s][l][QB-1]};
        if (t >= {1'b0, dv[s][l]}) begin
          rem_next[s][l] = DW'(t - {1'b0, dv[s][l]});
          q_next[s][l]   = {q[s][l][QB-2:0], 1'b1};
        end else begin
          rem_next[s][l] = DW'(t);
          q_next[s][l]   = {q[s][l][QB-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    logic [QB-1:0] qm;
    for (int l = 0; l < LANES; l++) begin
      qm = (sat[QB][l] || (q[QB][l] > TSAT)) ? TSAT : q[QB][l];
      quot_next[l] = sg[QB][l] ? -{1'b0, qm} : {1'b0, qm};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid     <= {valid[QB-1:0], in_valid};
      out_valid <= valid[QB];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= in_side;
      rem[0]  <= rem_in;
      dv[0]   <= den;
      q[0]    <= '0;
      sat[0]  <= sat_in;
      sg[0]   <= neg;
      for (int l = 0; l < LANES; l++) begin
        low[0][l] <= num[l][QB-1:0];
      end
      for (int s = 1; s <= QB; s++) begin
        side[s] <= side[s-1];
        rem[s]  <= rem_next[s-1];
        dv[s]   <= dv[s-1];
        q[s]    <= q_next[s-1];
        sat[s]  <= sat[s-1];
        sg[s]   <= sg[s-1];
        for (int l = 0; l < LANES; l++) begin
          low[s][l] <= low[s-1][l] << 1;
        end
      end
      out_side <= side[QB];
      quot     <= quot_next;
    end
  end

endmodule

@@ sv/ray_cylinder_entry_distance_unit.sv @@
// Top level: ray against capped vertical cylinder, nearest entry parameter.
`timescale 1ns / 1ps

// Usage
//   Input channel s_axis: one item per ray/cylinder pair, fields packed in
//   s_axis_tdata from bit 0 up. Output channel m_axis: one result item per
//   input item, in order, with hit in bit 0 and entry_t above it.
//   Throughput: one item per cycle while the pipeline is not held (see Stall).
//   Path from acceptance to the result appearing on m_axis:
//   7 front-end stages (differences, products, sums, partial products of
//   p^2 and a*c, discriminant), 52 square-root stages (one root bit each),
//   one numerator stage, 43 divider stages (overflow check, 41 quotient
//   bits, saturation), one slab clamp stage and the output buffer.
//   Reset (rst, synchronous) empties every stage and the output buffer.
//   Stall: the whole pipeline holds while the two-entry output buffer is
//   full and m_axis_tready is low; a held result stays on m_axis. With one
//   free entry the pipeline keeps moving, so input is still taken while a
//   finished result waits to be collected.
//   entry_t is zero on a miss.

module ray_cylinder_entry_distance_unit #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, axis_x, axis_z,
  // cyl_radius, bottom_y, top_y, range_limit (bit 0 up), zero filled
  input  logic [343:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // hit, entry_t (bit 0 up)
  output logic [31:0]  m_axis_tdata
);

  localparam int NUMW = rced_pkg::PW + FRAC_BITS;
  localparam int K    = rced_pkg::SQK;
  localparam int QW   = rced_pkg::QW;

  logic en;

  // Unpack input fields
  logic signed [31:0] f_px, f_py, f_pz, f_ax, f_az, f_r, f_bot, f_top;
  logic signed [17:0] f_dx, f_dy, f_dz;
  logic [30:0]        f_lim;

  assign f_px  = s_axis_tdata[31:0];
  assign f_py  = s_axis_tdata[63:32];
  assign f_pz  = s_axis_tdata[95:64];
  assign f_dx  = s_axis_tdata[113:96];
  assign f_dy  = s_axis_tdata[131:114];
  assign f_dz  = s_axis_tdata[149:132];
  assign f_ax  = s_axis_tdata[181:150];
  assign f_az  = s_axis_tdata[213:182];
  assign f_r   = s_axis_tdata[245:214];
  assign f_bot = s_axis_tdata[277:246];
  assign f_top = s_axis_tdata[309:278];
  assign f_lim = s_axis_tdata[340:310];

  assign s_axis_tready = en;

  // Stage 1: offsets from the axis, slab numerators, early miss flags
  logic                v1;
  logic signed [32:0]  ox1, oz1;
  logic signed [17:0]  dx1, dz1;
  logic signed [31:0]  r1;
  rced_pkg::sq_side_t  sd1;
  rced_pkg::sq_side_t  sd1_next;

  always_comb begin
    sd1_next       = '0;
    sd1_next.nb    = {f_bot[31], f_bot} - {f_py[31], f_py};
    sd1_next.nt    = {f_top[31], f_top} - {f_py[31], f_py};
    sd1_next.dy    = f_dy;
    sd1_next.lim   = f_lim;
    // bad cylinder: no radius or empty height span
    sd1_next.bad   = (f_r <= 32'sd0) || (f_top <= f_bot);
    // horizontal ray whose origin lies outside the slab
    sd1_next.hmiss = (f_dy == 18'sd0) && ((f_py < f_bot) || (f_py > f_top));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ox1 <= {f_px[31], f_px} - {f_ax[31], f_ax};
      oz1 <= {f_pz[31], f_pz} - {f_az[31], f_az};
      dx1 <= f_dx;
      dz1 <= f_dz;
      r1  <= f_r;
      sd1 <= sd1_next;
    end
  end

  // Stage 2: squares and dot-product terms
  logic                v2;
  logic signed [65:0]  sqx2, sqz2;
  logic signed [63:0]  rr2;
  logic signed [50:0]  pxd2, pzd2;
  logic signed [35:0]  dxx2, dzz2;
  rced_pkg::sq_side_t  sd2;

  always_ff @(posedge clk) begin
    if (en) begin
      sqx2 <= ox1 * ox1;
      sqz2 <= oz1 * oz1;
      rr2  <= r1 * r1;
      pxd2 <= ox1 * dx1;
      pzd2 <= oz1 * dz1;
      dxx2 <= dx1 * dx1;
      dzz2 <= dz1 * dz1;
      sd2  <= sd1;
    end
  end

  // Stage 3: a, p and c = |o|^2 - r^2
  logic                v3;
  logic signed [66:0]  c3;
  rced_pkg::sq_side_t  sd3;
  rced_pkg::sq_side_t  sd3_next;

  always_comb begin
    sd3_next   = sd2;
    sd3_next.a = 36'(dxx2 + dzz2);
    sd3_next.p = 52'(pxd2) + 52'(pzd2);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c3  <= 67'(sqx2) + 67'(sqz2) - 67'(rr2);
      sd3 <= sd3_next;
    end
  end

  // Stage 4: split |p| and |c| into pieces for the wide products
  logic [50:0]          pm_c;
  logic [65:0]          cm_c;
  logic                 v4;
  logic [51:0]          pll4;
  logic [50:0]          plh4;
  logic [49:0]          phh4;
  logic [5:0][39:0]     acp4;
  logic                 cneg4;
  rced_pkg::sq_side_t   sd4;
  rced_pkg::sq_side_t   sd4_next;

  assign pm_c = sd3.p[51] ? 51'(-sd3.p) : 51'(sd3.p);
  assign cm_c = c3[66] ? 66'(-c3) : 66'(c3);

  always_comb begin
    sd4_next     = sd3;
    // origin inside the infinite cylinder (used for vertical rays)
    sd4_next.vin = (c3 <= 67'sd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pll4    <= pm_c[25:0] * pm_c[25:0];
      plh4    <= pm_c[25:0] * pm_c[50:26];
      phh4    <= pm_c[50:26] * pm_c[50:26];
      acp4[0] <= sd3.a[17:0] * cm_c[21:0];
      acp4[1] <= sd3.a[17:0] * cm_c[43:22];
      acp4[2] <= sd3.a[17:0] * cm_c[65:44];
      acp4[3] <= sd3.a[35:18] * cm_c[21:0];
      acp4[4] <= sd3.a[35:18] * cm_c[43:22];
      acp4[5] <= sd3.a[35:18] * cm_c[65:44];
      cneg4   <= c3[66];
      sd4     <= sd4_next;
    end
  end

  // Stage 5: p^2 and the two halves of a*|c|
  logic                v5;
  logic [101:0]        p2_5;
  logic [85:0]         acl5, ach5;
  logic                cneg5;
  rced_pkg::sq_side_t  sd5;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_5  <= (102'(phh4) << 52) + (102'(plh4) << 27) + 102'(pll4);
      acl5  <= 86'(acp4[0]) + (86'(acp4[1]) << 22) + (86'(acp4[2]) << 44);
      ach5  <= 86'(acp4[3]) + (86'(acp4[4]) << 22) + (86'(acp4[5]) << 44);
      cneg5 <= cneg4;
      sd5   <= sd4;
    end
  end

  // Stage 6: combine a*|c|
  logic                v6;
  logic [101:0]        p2_6, acm6;
  logic                cneg6;
  rced_pkg::sq_side_t  sd6;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_6  <= p2_5;
      acm6  <= 102'(acl5) + (102'(ach5) << 18);
      cneg6 <= cneg5;
      sd6   <= sd5;
    end
  end

  // Stage 7: discriminant p^2 - a*c
  logic [104:0]        disc_c;
  logic                v7;
  logic [104:0]        disc7;
  rced_pkg::sq_side_t  sd7;
  rced_pkg::sq_side_t  sd7_next;

  assign disc_c = cneg6 ? 105'(p2_6) + 105'(acm6) : 105'(p2_6) - 105'(acm6);

  always_comb begin
    sd7_next      = sd6;
    sd7_next.dneg = disc_c[104];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disc7 <= disc_c;
      sd7   <= sd7_next;
    end
  end

  // Valid bits of the front end
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
    end else if (en) begin
      v1 <= s_axis_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
      v7 <= v6;
    end
  end

  // Square root of the discriminant (garbage when negative, flagged by dneg)
  logic                sq_valid;
  logic [K-1:0]        sq_root;
  rced_pkg::sq_side_t  sq_side;

  rced_sqrt_pipe #(
    .K (K)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v7),
    .rad       (disc7[2*K-1:0]),
    .in_side   (sd7),
    .out_valid (sq_valid),
    .root_out  (sq_root),
    .out_side  (sq_side)
  );

  // Numerator stage: slab lanes 0/1 divide by |dy|, radial lanes 2/3 by a
  logic signed [53:0]          pe_c, se_c, nlo_c, nhi_c;
  logic [51:0]                 nlom_c, nhim_c;
  logic [32:0]                 nbm_c, ntm_c;
  logic [17:0]                 dym_c;
  logic                        vn;
  logic [3:0][NUMW-1:0]        num_n;
  logic [3:0][rced_pkg::AW-1:0] den_n;
  logic [3:0]                  neg_n;
  rced_pkg::div_side_t         ds_n;

  assign pe_c   = 54'(sq_side.p);
  assign se_c   = {2'b00, sq_root};
  assign nlo_c  = -pe_c - se_c;
  assign nhi_c  = se_c - pe_c;
  assign nlom_c = nlo_c[53] ? 52'(-nlo_c) : 52'(nlo_c);
  assign nhim_c = nhi_c[53] ? 52'(-nhi_c) : 52'(nhi_c);
  assign nbm_c  = sq_side.nb[32] ? 33'(-sq_side.nb) : 33'(sq_side.nb);
  assign ntm_c  = sq_side.nt[32] ? 33'(-sq_side.nt) : 33'(sq_side.nt);
  assign dym_c  = sq_side.dy[17] ? 18'(-sq_side.dy) : 18'(sq_side.dy);

  always_ff @(posedge clk) begin
    if (rst) begin
      vn <= 1'b0;
    end else if (en) begin
      vn <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_n[0]   <= NUMW'({nbm_c, {FRAC_BITS{1'b0}}});
      num_n[1]   <= NUMW'({ntm_c, {FRAC_BITS{1'b0}}});
      num_n[2]   <= {nlom_c, {FRAC_BITS{1'b0}}};
      num_n[3]   <= {nhim_c, {FRAC_BITS{1'b0}}};
      den_n[0]   <= rced_pkg::AW'(dym_c);
      den_n[1]   <= rced_pkg::AW'(dym_c);
      den_n[2]   <= sq_side.a;
      den_n[3]   <= sq_side.a;
      neg_n[0]   <= sq_side.nb[32] ^ sq_side.dy[17];
      neg_n[1]   <= sq_side.nt[32] ^ sq_side.dy[17];
      neg_n[2]   <= nlo_c[53];
      neg_n[3]   <= nhi_c[53];
      ds_n.lim   <= sq_side.lim;
      ds_n.bad   <= sq_side.bad;
      ds_n.hmiss <= sq_side.hmiss;
      ds_n.dyz   <= (sq_side.dy == 18'sd0);
      ds_n.az    <= (sq_side.a == '0);
      ds_n.vin   <= sq_side.vin;
      ds_n.dneg  <= sq_side.dneg;
    end
  end

  // Four saturating dividers in lockstep
  logic                     dv_valid;
  rced_pkg::div_side_t      dside;
  logic [3:0][QW-1:0]       dq;

  rced_div_pipe #(
    .NW    (NUMW),
    .DW    (rced_pkg::AW),
    .LANES (4)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (vn),
    .in_side   (ds_n),
    .num       (num_n),
    .den       (den_n),
    .neg       (neg_n),
    .out_valid (dv_valid),
    .out_side  (dside),
    .quot      (dq)
  );

  // Clamp stage: order the slab bounds and clip them to [0, limit]
  logic signed [QW-1:0] ta_c, tb_c, smin_c, smax_c, lim_c, ty0_c, ty1_c;
  logic                 vc;
  logic signed [QW-1:0] ty0c, ty1c, tloc, thic;
  logic                 missc, azc, vinc, dnegc;

  assign ta_c   = $signed(dq[0]);
  assign tb_c   = $signed(dq[1]);
  assign smin_c = (ta_c < tb_c) ? ta_c : tb_c;
  assign smax_c = (ta_c < tb_c) ? tb_c : ta_c;
  assign lim_c  = QW'(dside.lim);
  assign ty0_c  = dside.dyz ? '0 : ((smin_c > 0) ? smin_c : '0);
  assign ty1_c  = dside.dyz ? lim_c : ((smax_c < lim_c) ? smax_c : lim_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ty0c  <= ty0_c;
      ty1c  <= ty1_c;
      tloc  <= $signed(dq[2]);
      thic  <= $signed(dq[3]);
      missc <= dside.bad || dside.hmiss || (ty0_c > ty1_c);
      azc   <= dside.az;
      vinc  <= dside.vin;
      dnegc <= dside.dneg;
    end
  end

  // Final decision: vertical rays test containment, others overlap intervals
  logic signed [QW-1:0] lo_c, hi_c;
  logic                 hit_c;
  logic [30:0]          ent_c;
  logic [31:0]          res_c;

  assign lo_c  = (tloc > ty0c) ? tloc : ty0c;
  assign hi_c  = (thic < ty1c) ? thic : ty1c;
  assign hit_c = !missc && (azc ? vinc : (!dnegc && (lo_c <= hi_c)));
  assign ent_c = !hit_c ? '0 : (azc ? ty0c[30:0] : lo_c[30:0]);
  assign res_c = {ent_c, hit_c};

  // Two-entry output buffer; the pipeline holds only when it is full
  logic [1:0]  out_cnt;
  logic [31:0] out_buf0, out_buf1;
  logic        push, pop;

  assign pop  = m_axis_tvalid && m_axis_tready;
  assign push = vc && en;
  assign en   = (out_cnt != 2'd2) || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_cnt <= '0;
    end else begin
      out_cnt <= out_cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      // advance the head; a new item lands behind whatever remains
      out_buf0 <= (out_cnt == 2'd2) ? out_buf1 : res_c;
      if (push && (out_cnt == 2'd2)) begin
        out_buf1 <= res_c;
      end
    end else if (push) begin
      if (out_cnt == 2'd0) begin
        out_buf0 <= res_c;
      end else begin
        out_buf1 <= res_c;
      end
    end
  end

  assign m_axis_tvalid = (out_cnt != 2'd0);
  assign m_axis_tdata  = out_buf0;

endmodule
